[sv/http_request_line_query_decoder_unit_macros.svh]
// ----------------------------------------------------------------------------
// HTTP request line query decoder - assertion macros
// Shared concurrent assertion forms, clocked on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_QUERY_DECODER_UNIT_MACROS_SVH
`define HTTP_REQUEST_LINE_QUERY_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define HRQD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hrqd: same-cycle check failed");

// next-cycle implication
`define HRQD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hrqd: next-cycle check failed");

`endif

[sv/hrqd_pkg.sv]
// ----------------------------------------------------------------------------
// hrqd_pkg
// Types and byte constants for the request line query decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrqd_pkg;

    localparam int LEN_W = 10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_METHOD    = 2'd1,
        ST_BAD_REQ   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        TP_PRE_METHOD = 3'd0,
        TP_METHOD     = 3'd1,
        TP_BETWEEN    = 3'd2,
        TP_TARGET     = 3'd3,
        TP_AFTER      = 3'd4
    } token_phase_t;

    typedef enum logic [1:0] {
        PATH_EMPTY = 2'd0,
        PATH_ROOT  = 2'd1,
        PATH_OTHER = 2'd2
    } path_t;

    typedef enum logic [2:0] {
        PAIR_START = 3'd0,
        PAIR_SAW_Q = 3'd1,
        PAIR_VALUE = 3'd2,
        PAIR_SKIP  = 3'd3,
        PAIR_DONE  = 3'd4
    } pair_t;

    typedef enum logic [1:0] {
        HEX_IDLE = 2'd0,
        HEX_HIGH = 2'd1,
        HEX_LOW  = 2'd2
    } hex_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        status_t          status;
        logic [LEN_W-1:0] len;
        logic             last;
    } result_t;

    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

`default_nettype wire

[sv/hrqd_parse.sv]
// ----------------------------------------------------------------------------
// hrqd_parse
// Request line state and per-byte step: tokens, method, path, query decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrqd_parse (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    step,
    input  wire logic [7:0]              line_byte,
    input  wire logic                    line_end,
    input  wire logic [hrqd_pkg::LEN_W-1:0] limit,
    output hrqd_pkg::result_t            res0,
    output hrqd_pkg::result_t            res1,
    output logic [1:0]                   res_count
);
    import hrqd_pkg::*;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        return v;
    endfunction

    token_phase_t     tp_reg, tp_next;
    logic [1:0]       mpos_reg, mpos_next;
    logic             mbad_reg, mbad_next;
    logic             pdot_reg, pdot_next;
    logic             dotdot_reg, dotdot_next;
    path_t            path_reg, path_next;
    logic             inq_reg, inq_next;
    pair_t            pair_reg, pair_next;
    hex_t             hex_reg, hex_next;
    logic [3:0]       nib_reg, nib_next;
    logic             fail_reg, fail_next;
    logic [LEN_W-1:0] qcnt_reg, qcnt_next;

    logic             ws;
    logic             do_method, do_target, do_query, do_end_target;
    logic             try_emit, emit;
    logic [7:0]       emit_data;
    logic [4:0]       hv;
    status_t          v_status;
    logic [LEN_W-1:0] v_len;

    assign ws = (line_byte == CH_SPACE) || (line_byte >= 8'd9 && line_byte <= 8'd13);

    // next state
    always_comb begin
        tp_next     = tp_reg;
        mpos_next   = mpos_reg;
        mbad_next   = mbad_reg;
        pdot_next   = pdot_reg;
        dotdot_next = dotdot_reg;
        path_next   = path_reg;
        inq_next    = inq_reg;
        pair_next   = pair_reg;
        hex_next    = hex_reg;
        nib_next    = nib_reg;
        fail_next   = fail_reg;
        qcnt_next   = qcnt_reg;
        do_method   = 1'b0;
        do_target   = 1'b0;
        do_query    = 1'b0;
        do_end_target = 1'b0;
        try_emit    = 1'b0;
        emit        = 1'b0;
        emit_data   = line_byte;
        hv          = hex_val(line_byte);
        v_status    = ST_OK;
        v_len       = '0;

        case (tp_reg)
            TP_PRE_METHOD: begin
                if (!ws) begin
                    tp_next   = TP_METHOD;
                    do_method = 1'b1;
                end
            end
            TP_METHOD: begin
                if (ws) begin
                    if (mpos_reg != 2'd3) mbad_next = 1'b1;
                    tp_next = TP_BETWEEN;
                end else begin
                    do_method = 1'b1;
                end
            end
            TP_BETWEEN: begin
                if (!ws) begin
                    tp_next   = TP_TARGET;
                    do_target = 1'b1;
                end
            end
            TP_TARGET: begin
                if (ws) do_end_target = 1'b1;
                else    do_target     = 1'b1;
            end
            default: ;
        endcase

        if (do_method) begin
            if ((mpos_reg == 2'd0 && line_byte == CH_G) ||
                (mpos_reg == 2'd1 && line_byte == CH_E) ||
                (mpos_reg == 2'd2 && line_byte == CH_T)) begin
                mpos_next = mpos_reg + 2'd1;
            end else begin
                mbad_next = 1'b1;
            end
        end

        if (do_target) begin
            if (pdot_reg && line_byte == CH_DOT) dotdot_next = 1'b1;
            pdot_next = (line_byte == CH_DOT);
            if (!inq_reg) begin
                if (line_byte == CH_QMARK) inq_next = 1'b1;
                else path_next = (path_reg == PATH_EMPTY && line_byte == CH_SLASH) ?
                                 PATH_ROOT : PATH_OTHER;
            end else begin
                do_query = 1'b1;
            end
        end

        if (do_query) begin
            case (pair_reg)
                PAIR_START: pair_next = (line_byte == CH_Q)   ? PAIR_SAW_Q :
                                        (line_byte == CH_AMP) ? PAIR_START : PAIR_SKIP;
                PAIR_SAW_Q: pair_next = (line_byte == CH_EQ)  ? PAIR_VALUE :
                                        (line_byte == CH_AMP) ? PAIR_START : PAIR_SKIP;
                PAIR_SKIP: begin
                    if (line_byte == CH_AMP) pair_next = PAIR_START;
                end
                PAIR_VALUE: begin
                    if (hex_reg != HEX_IDLE) begin
                        if (hv[4]) begin
                            fail_next = 1'b1;
                            pair_next = PAIR_DONE;
                            hex_next  = HEX_IDLE;
                        end else if (hex_reg == HEX_HIGH) begin
                            nib_next = hv[3:0];
                            hex_next = HEX_LOW;
                        end else begin
                            hex_next  = HEX_IDLE;
                            try_emit  = 1'b1;
                            emit_data = {nib_reg, hv[3:0]};
                        end
                    end else if (line_byte == CH_AMP) begin
                        pair_next = PAIR_DONE;
                    end else if (line_byte == CH_PCT) begin
                        hex_next = HEX_HIGH;
                    end else begin
                        try_emit  = 1'b1;
                        emit_data = (line_byte == CH_PLUS) ? CH_SPACE : line_byte;
                    end
                end
                default: ;
            endcase
        end

        if (try_emit && !mbad_next && !dotdot_next && path_next == PATH_ROOT &&
            qcnt_reg < limit) begin
            emit      = 1'b1;
            qcnt_next = qcnt_reg + LEN_W'(1);
        end

        if (line_end) begin
            if (tp_next == TP_PRE_METHOD) mbad_next = 1'b1;
            else if (tp_next == TP_METHOD && mpos_next != 2'd3) mbad_next = 1'b1;
            if (tp_next == TP_TARGET) do_end_target = 1'b1;
        end

        if (do_end_target) begin
            if (pair_next == PAIR_VALUE && hex_next != HEX_IDLE) begin
                fail_next = 1'b1;
                pair_next = PAIR_DONE;
            end
            tp_next = TP_AFTER;
        end

        priority if (mbad_next)            v_status = ST_METHOD;
        else if (dotdot_next)              v_status = ST_BAD_REQ;
        else if (path_next != PATH_ROOT)   v_status = ST_NOT_FOUND;
        else                               v_status = ST_OK;
        v_len = (v_status == ST_OK && !fail_next) ? qcnt_next : '0;

        if (line_end) begin
            tp_next     = TP_PRE_METHOD;
            mpos_next   = 2'd0;
            mbad_next   = 1'b0;
            pdot_next   = 1'b0;
            dotdot_next = 1'b0;
            path_next   = PATH_EMPTY;
            inq_next    = 1'b0;
            pair_next   = PAIR_START;
            hex_next    = HEX_IDLE;
            nib_next    = 4'd0;
            fail_next   = 1'b0;
            qcnt_next   = '0;
        end
    end

    // results
    always_comb begin
        result_t prov;
        result_t verd;
        prov.kind   = 1'b0;
        prov.data   = emit_data;
        prov.status = ST_OK;
        prov.len    = '0;
        prov.last   = !line_end;
        verd.kind   = 1'b1;
        verd.data   = 8'd0;
        verd.status = v_status;
        verd.len    = v_len;
        verd.last   = 1'b1;
        res0        = emit ? prov : verd;
        res1        = verd;
        res_count   = {1'b0, emit} + {1'b0, line_end};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tp_reg     <= TP_PRE_METHOD;
            mpos_reg   <= 2'd0;
            mbad_reg   <= 1'b0;
            pdot_reg   <= 1'b0;
            dotdot_reg <= 1'b0;
            path_reg   <= PATH_EMPTY;
            inq_reg    <= 1'b0;
            pair_reg   <= PAIR_START;
            hex_reg    <= HEX_IDLE;
            nib_reg    <= 4'd0;
            fail_reg   <= 1'b0;
            qcnt_reg   <= '0;
        end else if (step) begin
            tp_reg     <= tp_next;
            mpos_reg   <= mpos_next;
            mbad_reg   <= mbad_next;
            pdot_reg   <= pdot_next;
            dotdot_reg <= dotdot_next;
            path_reg   <= path_next;
            inq_reg    <= inq_next;
            pair_reg   <= pair_next;
            hex_reg    <= hex_next;
            nib_reg    <= nib_next;
            fail_reg   <= fail_next;
            qcnt_reg   <= qcnt_next;
        end
    end

endmodule

`default_nettype wire

[sv/http_request_line_query_decoder_unit.sv]
// ----------------------------------------------------------------------------
// http_request_line_query_decoder_unit
// Parses an HTTP request line one byte per word, decodes the q= query value
// and closes each line with a verdict word.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser       | tlast
//  s_       | in  | [7:0] line_byte                | -           | line_end
//  m_       | out | [7:0] query_byte [9:8] status  | result_kind | run_last
//           |     | [19:10] query_len [23:20] zero |             |
//  cfg_     | in  | cfg_data [9:0] max_query_len   | -           | -
//
//  One byte per cycle while the queue has room: input register, one step of
//  parse logic, then a four-word result queue. A byte is stepped when the
//  queue has room for two words; the line-end byte may produce two words, so
//  a stalled m_ side fills the queue and pushes back on s_tready. Reset
//  returns the parser to the start of a line and sets max_query_len to 256;
//  s_tready rises as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_query_decoder_unit #(
    parameter int QUERY_LEN_MAX = 1023
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] line_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] query_byte, [9:8] status, [19:10] query_len
    output logic             m_tuser,   // result_kind
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);
    import hrqd_pkg::*;

    localparam int CMP_W = 17;

    logic [LEN_W-1:0] maxq_reg;
    logic [LEN_W-1:0] limit;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       s_fire, step;

    result_t    res0, res1;
    logic [1:0] res_count;

    result_t    q_mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    result_t    head;

    assign cfg_ready = aresetn;
    assign limit = ({{(CMP_W-LEN_W){1'b0}}, maxq_reg} < CMP_W'(QUERY_LEN_MAX)) ?
                   maxq_reg : LEN_W'(QUERY_LEN_MAX);

    assign step          = in_valid_reg && (cnt_reg <= 3'd2);
    assign s_tready      = aresetn && (!in_valid_reg || step);
    assign s_fire        = s_tvalid && s_tready;
    assign in_valid_next = s_fire ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maxq_reg     <= LEN_W'(256);
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) maxq_reg <= cfg_data;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    hrqd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .line_byte (in_byte_reg),
        .line_end  (in_last_reg),
        .limit     (limit),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {4'd0, head.len, head.status, head.data};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    always_comb begin
        cnt_next = cnt_reg - {2'd0, pop};
        if (step) cnt_next = cnt_next + {1'b0, res_count};
    end

    always_ff @(posedge aclk) begin
        if (step && res_count != 2'd0) q_mem[wr_ptr_reg] <= res0;
        if (step && res_count == 2'd2) q_mem[wr_ptr_reg + 2'd1] <= res1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end else begin
            if (step) wr_ptr_reg <= wr_ptr_reg + res_count;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[sv/hrqd_check.sv]
// ----------------------------------------------------------------------------
// hrqd_check
// Port-level checks on the result stream of the query decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_line_query_decoder_unit_macros.svh"

module hrqd_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `HRQD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `HRQD_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `HRQD_ASSERT_NOW(a_verdict_last, m_tvalid && m_tuser, m_tlast)
    `HRQD_ASSERT_NOW(a_prov_clean, m_tvalid && !m_tuser, m_tdata[23:8] == 16'd0)
    `HRQD_ASSERT_NOW(a_fail_no_len, m_tvalid && m_tuser && m_tdata[9:8] != 2'd0,
                     m_tdata[19:10] == 10'd0 && m_tdata[7:0] == 8'd0)

endmodule

bind http_request_line_query_decoder_unit hrqd_check u_hrqd_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
